// ----- hdl/dod_pkg.sv -----
// ----------------------------------------------------------------------------
// dod_pkg
// Shared widths, codes and handshake structs of the DOD history tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package dod_pkg;

  localparam int HIST_DEPTH = 50;
  localparam int DOD_W      = 10;
  localparam int SOC_W      = 10;
  localparam int TMR_W      = 12;
  localparam int DIR_W      = 2;
  localparam int CNT_OUT_W  = 6;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int SUM_W      = DOD_W + FILL_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int FULL_SOC   = 1000;
  localparam int CNT_SAT    = 63;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [DIR_W-1:0] DIR_IDLE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CHG   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DSG   = 2'd2;

  localparam logic [1:0] STORE_NONE = 2'd0;
  localparam logic [1:0] STORE_ALL  = 2'd1;
  localparam logic [1:0] STORE_NOW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_NOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_AVG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE       = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DOD_W-1:0]  nd;
    logic [FILL_W-1:0] fill;
  } hist_req_t;

  typedef struct packed {
    logic             done;
    logic [DOD_W-1:0] max_dod;
    logic [DOD_W-1:0] avg_dod;
  } hist_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/dod_in_if.sv -----
// ----------------------------------------------------------------------------
// dod_in_if
// Input channel: one tick or clear item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dod_in_if import dod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic             init_phase;
  logic [DIR_W-1:0] direction;
  logic [SOC_W-1:0] soc;

  modport source (output valid, output opcode, output init_phase, output direction,
                  output soc, input ready);
  modport sink   (input valid, input opcode, input init_phase, input direction,
                  input soc, output ready);
endinterface

`default_nettype wire

// ----- hdl/dod_out_if.sv -----
// ----------------------------------------------------------------------------
// dod_out_if
// Result channel: depth statistics and save request for one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dod_out_if import dod_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DOD_W-1:0]     now_dod;
  logic [DOD_W-1:0]     first_dod;
  logic [DOD_W-1:0]     max_dod;
  logic [DOD_W-1:0]     avg_dod;
  logic [CNT_OUT_W-1:0] history_count;
  logic                 record_created;
  logic [1:0]           store_action;

  modport source (output valid, output now_dod, output first_dod, output max_dod,
                  output avg_dod, output history_count, output record_created,
                  output store_action, input ready);
  modport sink   (input valid, input now_dod, input first_dod, input max_dod,
                  input avg_dod, input history_count, input record_created,
                  input store_action, output ready);
endinterface

`default_nettype wire

// ----- hdl/battery_dod_history_tracker.sv -----
// ----------------------------------------------------------------------------
// battery_dod_history_tracker
// Depth-of-discharge tracking with a record history and max/average stats.
// ----------------------------------------------------------------------------
// An item that adds no history record is answered in the cycle after it is taken;
// the next item may follow once its result has been taken or is being taken.
// An item that adds a record runs through the history block: the new depth is
// shifted into a ring of history cells, the ring is rotated once around to
// collect max and sum, and a restoring divider produces the average one bit
// per cycle. No item is accepted while that runs. Configuration writes to the
// initial_* registers also load the matching statistic.
`default_nettype none

module battery_dod_history_tracker import dod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dod_in_if.sink                in_ch,
  dod_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } ctl_st_t;

  ctl_st_t st_r;

  logic [TMR_W-1:0] hold_r;
  logic [DOD_W-1:0] drop_r, low_r, step_r;

  logic [DOD_W-1:0]  now_r, now_nxt;
  logic [DOD_W-1:0]  first_r, first_nxt;
  logic [DOD_W-1:0]  max_r, max_nxt;
  logic [DOD_W-1:0]  avg_r, avg_nxt;
  logic              pend_r, pend_nxt;
  logic [TMR_W-1:0]  dtmr_r, dtmr_nxt;
  logic              ctmr_r, ctmr_nxt;
  logic [SOC_W-1:0]  held_r, held_nxt;
  logic [DOD_W-1:0]  saved_r, saved_nxt;
  logic              saved_vld_r, saved_vld_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic                 o_vld_r;
  logic [DOD_W-1:0]     o_now_r, o_first_r, o_max_r, o_avg_r;
  logic [CNT_OUT_W-1:0] o_cnt_r;
  logic                 o_rec_r;
  logic [1:0]           o_store_r;

  logic             accept;
  logic             out_take;
  logic             created;
  logic [1:0]       store;
  logic [DOD_W-1:0] soc_dod;
  logic [DOD_W-1:0] held_dod;
  logic             restart;
  logic [DOD_W-1:0] diff;
  logic [CNT_OUT_W-1:0] cnt_sat;
  hist_req_t        hreq;
  hist_rsp_t        hrsp;

  assign in_ch.ready = (st_r == ST_IDLE) && (!o_vld_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_take    = o_vld_r && out_ch.ready;

  assign soc_dod  = (in_ch.soc <= SOC_W'(FULL_SOC)) ? DOD_W'(SOC_W'(FULL_SOC) - in_ch.soc) : '0;
  assign held_dod = (held_r <= SOC_W'(FULL_SOC)) ? DOD_W'(SOC_W'(FULL_SOC) - held_r) : '0;
  assign restart  = ({1'b0, in_ch.soc} + {1'b0, drop_r} <= {1'b0, held_r})
                    || (in_ch.soc < low_r);

  always_comb begin
    now_nxt       = now_r;
    first_nxt     = first_r;
    max_nxt       = max_r;
    avg_nxt       = avg_r;
    pend_nxt      = pend_r;
    dtmr_nxt      = dtmr_r;
    ctmr_nxt      = ctmr_r;
    held_nxt      = held_r;
    saved_nxt     = saved_r;
    saved_vld_nxt = saved_vld_r;
    fill_nxt      = fill_r;
    created       = 1'b0;
    store         = STORE_NONE;
    diff          = '0;
    if (in_ch.opcode == OP_CLEAR) begin
      now_nxt   = '0;
      first_nxt = '0;
      max_nxt   = '0;
      avg_nxt   = '0;
      fill_nxt  = '0;
      store     = STORE_ALL;
    end else if (in_ch.init_phase) begin
      ctmr_nxt = 1'b0;
      dtmr_nxt = '0;
      held_nxt = in_ch.soc;
    end else begin
      if (in_ch.direction == DIR_DSG) begin
        if (soc_dod > now_r) begin
          dtmr_nxt = '0;
          pend_nxt = 1'b1;
          now_nxt  = soc_dod;
          if (first_r > soc_dod) first_nxt = soc_dod;
        end else if (dtmr_r >= hold_r) begin
          // discharge restarted after a long hold
          if (restart) begin
            dtmr_nxt  = '0;
            pend_nxt  = 1'b1;
            first_nxt = held_dod;
            now_nxt   = soc_dod;
          end
        end else begin
          dtmr_nxt = dtmr_r + TMR_W'(1);
        end
        ctmr_nxt = 1'b0;
      end else begin
        if (soc_dod > now_r) begin
          pend_nxt = 1'b1;
          now_nxt  = soc_dod;
        end
        if ((in_ch.direction == DIR_CHG) && pend_nxt && saved_vld_r) begin
          if (ctmr_r) begin
            created  = 1'b1;
            ctmr_nxt = 1'b0;
            pend_nxt = 1'b0;
            fill_nxt = (int'(fill_r) < HIST_DEPTH) ? fill_r + FILL_W'(1)
                                                   : FILL_W'(HIST_DEPTH);
          end else begin
            ctmr_nxt = 1'b1;
          end
        end else begin
          ctmr_nxt = 1'b0;
        end
        if (in_ch.direction == DIR_CHG) begin
          dtmr_nxt = '0;
          held_nxt = in_ch.soc;
        end
      end
      diff = (now_nxt >= saved_r) ? now_nxt - saved_r : saved_r - now_nxt;
      if (!saved_vld_r) begin
        pend_nxt      = 1'b1;
        saved_nxt     = now_nxt;
        saved_vld_nxt = 1'b1;
      end else if (created) begin
        store     = STORE_ALL;
        saved_nxt = now_nxt;
      end else if ((diff >= step_r) ||
                   ((diff != '0) && (in_ch.direction != DIR_DSG))) begin
        store     = STORE_NOW;
        saved_nxt = now_nxt;
      end
    end
  end

  assign cnt_sat = (int'(fill_nxt) > CNT_SAT) ? CNT_OUT_W'(CNT_SAT) : CNT_OUT_W'(fill_nxt);

  assign hreq.start = accept && created;
  assign hreq.nd    = now_nxt;
  assign hreq.fill  = fill_nxt;

  dod_history u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // control and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      o_vld_r     <= 1'b0;
      hold_r      <= TMR_W'(180);
      drop_r      <= DOD_W'(50);
      low_r       <= DOD_W'(30);
      step_r      <= DOD_W'(50);
      now_r       <= '0;
      first_r     <= '0;
      max_r       <= '0;
      avg_r       <= '0;
      pend_r      <= 1'b0;
      dtmr_r      <= '0;
      ctmr_r      <= 1'b0;
      held_r      <= '0;
      saved_vld_r <= 1'b0;
      fill_r      <= '0;
    end else begin
      if (accept) begin
        now_r       <= now_nxt;
        first_r     <= first_nxt;
        max_r       <= max_nxt;
        avg_r       <= avg_nxt;
        pend_r      <= pend_nxt;
        dtmr_r      <= dtmr_nxt;
        ctmr_r      <= ctmr_nxt;
        held_r      <= held_nxt;
        saved_vld_r <= saved_vld_nxt;
        fill_r      <= fill_nxt;
        o_vld_r     <= !created;
        st_r        <= created ? ST_WAIT : ST_IDLE;
      end else if (out_take) begin
        o_vld_r <= 1'b0;
      end
      if ((st_r == ST_WAIT) && hrsp.done) begin
        max_r   <= hrsp.max_dod;
        avg_r   <= hrsp.avg_dod;
        o_vld_r <= 1'b1;
        st_r    <= ST_IDLE;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_INIT_NOW:   now_r   <= cfg_data[DOD_W-1:0];
          CFG_INIT_FIRST: first_r <= cfg_data[DOD_W-1:0];
          CFG_INIT_MAX:   max_r   <= cfg_data[DOD_W-1:0];
          CFG_INIT_AVG:   avg_r   <= cfg_data[DOD_W-1:0];
          CFG_HOLD:       hold_r  <= cfg_data[TMR_W-1:0];
          CFG_DROP:       drop_r  <= cfg_data[DOD_W-1:0];
          CFG_LOW:        low_r   <= cfg_data[DOD_W-1:0];
          CFG_SAVE:       step_r  <= cfg_data[DOD_W-1:0];
          default:        step_r  <= step_r;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      saved_r   <= saved_nxt;
      o_now_r   <= now_nxt;
      o_first_r <= first_nxt;
      o_max_r   <= max_nxt;
      o_avg_r   <= avg_nxt;
      o_cnt_r   <= cnt_sat;
      o_rec_r   <= created;
      o_store_r <= store;
    end
    if ((st_r == ST_WAIT) && hrsp.done) begin
      o_max_r <= hrsp.max_dod;
      o_avg_r <= hrsp.avg_dod;
    end
  end

  assign out_ch.valid          = o_vld_r;
  assign out_ch.now_dod        = o_now_r;
  assign out_ch.first_dod      = o_first_r;
  assign out_ch.max_dod        = o_max_r;
  assign out_ch.avg_dod        = o_avg_r;
  assign out_ch.history_count  = o_cnt_r;
  assign out_ch.record_created = o_rec_r;
  assign out_ch.store_action   = o_store_r;

endmodule

`default_nettype wire

// ----- hdl/dod_hist_cell.sv -----
// ----------------------------------------------------------------------------
// dod_hist_cell
// One history slot; takes its neighbor's value when the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_hist_cell import dod_pkg::*; (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [DOD_W-1:0] d_in,
  output logic [DOD_W-1:0] q
);

  logic [DOD_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign q = val_r;

endmodule

`default_nettype wire

// ----- hdl/dod_divider.sv -----
// ----------------------------------------------------------------------------
// dod_divider
// Restoring divider, one quotient bit per cycle, for the history average.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_divider import dod_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FILL_W-1:0] divisor,
  output logic              done,
  output logic [SUM_W-1:0]  quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FILL_W-1:0]    rem_r;
  logic [FILL_W-1:0]    dvs_r;
  logic [SUM_W-1:0]     quo_r;
  logic [FILL_W:0]      trial;
  logic                 fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? FILL_W'(trial - {1'b0, dvs_r}) : trial[FILL_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- hdl/dod_history.sv -----
// ----------------------------------------------------------------------------
// dod_history
// Ring of history cells: insert the newest depth, rotate the ring once
// around to gather max and sum over the valid records, then divide.
// ----------------------------------------------------------------------------
`default_nettype none

module dod_history import dod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output hist_rsp_t rsp
);

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_SCAN = 3'b010,
    H_DIV  = 3'b100
  } hist_st_t;

  hist_st_t          st_r, st_nxt;
  logic [IDX_W-1:0]  k_r;
  logic [FILL_W-1:0] fill_r;
  logic [DOD_W-1:0]  max_r, max_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DOD_W-1:0]  cell_q [HIST_DEPTH];
  logic [DOD_W-1:0]  cell_d [HIST_DEPTH];
  logic              shift_en;
  logic              scan_last;
  logic              take;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  assign shift_en  = ((st_r == H_IDLE) && req.start) || (st_r == H_SCAN);
  assign cell_d[0] = (st_r == H_IDLE) ? req.nd : cell_q[HIST_DEPTH-1];

  genvar gi;
  generate
    for (gi = 1; gi < HIST_DEPTH; gi++) begin : g_link
      assign cell_d[gi] = cell_q[gi-1];
    end
    for (gi = 0; gi < HIST_DEPTH; gi++) begin : g_cell
      dod_hist_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_d[gi]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  // the tail shows record HIST_DEPTH-1-k on scan step k
  assign take      = (HIST_DEPTH - 1 - int'(k_r)) < int'(fill_r);
  assign scan_last = (k_r == IDX_W'(HIST_DEPTH - 1));
  assign max_nxt   = (take && (cell_q[HIST_DEPTH-1] > max_r)) ? cell_q[HIST_DEPTH-1] : max_r;
  assign sum_nxt   = take ? sum_r + SUM_W'(cell_q[HIST_DEPTH-1]) : sum_r;
  assign div_start = (st_r == H_SCAN) && scan_last;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      H_IDLE: if (req.start) st_nxt = H_SCAN;
      H_SCAN: if (scan_last) st_nxt = H_DIV;
      H_DIV:  if (div_done) st_nxt = H_IDLE;
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == H_IDLE) && req.start) begin
      k_r    <= '0;
      fill_r <= req.fill;
      max_r  <= '0;
      sum_r  <= '0;
    end else if (st_r == H_SCAN) begin
      k_r   <= k_r + IDX_W'(1);
      max_r <= max_nxt;
      sum_r <= sum_nxt;
    end
  end

  dod_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rsp.done    = (st_r == H_DIV) && div_done;
  assign rsp.max_dod = max_r;
  assign rsp.avg_dod = div_quo[DOD_W-1:0];

endmodule

`default_nettype wire

// ----- tb/tb_battery_dod_history_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_battery_dod_history_tracker
// Drives tick and clear items into the DOD history tracker and compares every
// result against an in-bench prediction of depth, start depth, history max and
// average, record and save flags, or against the listed values of a typed row.
// A short directed table comes first. Random discharge/charge sequences follow,
// under several register settings, with random gaps and stalls on each channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_battery_dod_history_tracker;
  import dod_pkg::*;

  localparam logic [DIR_W-1:0] DIR_RSVD = 2'd3;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic             opcode;
    logic             init_phase;
    logic [DIR_W-1:0] direction;
    logic [SOC_W-1:0] soc;
  } tick_t;

  typedef struct packed {
    logic [DOD_W-1:0]     now_dod;
    logic [DOD_W-1:0]     first_dod;
    logic [DOD_W-1:0]     max_dod;
    logic [DOD_W-1:0]     avg_dod;
    logic [CNT_OUT_W-1:0] history_count;
    logic                 record_created;
    logic [1:0]           store_action;
  } dod_res_t;

  typedef struct {
    tick_t    t;
    bit       typed;
    dod_res_t want;
  } drill_row_t;

  localparam dod_res_t ALL_ZERO = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dod_in_if  in_ch();
  dod_out_if out_ch();

  battery_dod_history_tracker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Tracker state as the block should hold it
  logic [DOD_W-1:0]  trk_now = '0, trk_first = '0, trk_max = '0, trk_avg = '0;
  logic              trk_pending = 1'b0;
  logic [TMR_W-1:0]  trk_dsg_tmr = '0;
  logic              trk_chg_tmr = 1'b0;
  logic [SOC_W-1:0]  trk_held = '0;
  logic [DOD_W-1:0]  trk_saved = '0;
  logic              trk_saved_ok = 1'b0;
  logic [DOD_W-1:0]  hist_mem [HIST_DEPTH];
  int                hist_fill = 0;

  logic [TMR_W-1:0]  cfg_hold = 12'd180;
  logic [DOD_W-1:0]  cfg_drop = 10'd50;
  logic [DOD_W-1:0]  cfg_low  = 10'd30;
  logic [DOD_W-1:0]  cfg_save = 10'd50;
  logic [CFG_DATA_W-1:0] reg_plan [8];

  dod_res_t stats_due [$];
  int       mism_count = 0;
  int       results_seen = 0;
  bit       steady = 1'b0;
  bit       drill_typed = 1'b0;
  dod_res_t drill_want = '0;
  int       soc_walk = 600;

  drill_row_t drill [21];

  function automatic int depth_from(input logic [SOC_W-1:0] s);
    return (s <= FULL_SOC) ? FULL_SOC - int'(s) : 0;
  endfunction

  task automatic track_tick(input tick_t t, output dod_res_t r);
    int d, diff, len, mx, sum, num, i, v;
    logic created;
    logic [1:0] store;
    begin
      created = 1'b0;
      store   = STORE_NONE;
      if (t.opcode == OP_CLEAR) begin
        trk_now = '0; trk_first = '0; trk_max = '0; trk_avg = '0;
        hist_fill = 0;
        store = STORE_ALL;
      end else if (t.init_phase) begin
        trk_chg_tmr = 1'b0;
        trk_dsg_tmr = '0;
        trk_held    = t.soc;
      end else begin
        d = depth_from(t.soc);
        if (t.direction == DIR_DSG) begin
          if (d > int'(trk_now)) begin
            trk_dsg_tmr = '0;
            trk_pending = 1'b1;
            trk_now     = DOD_W'(d);
            if (trk_first > trk_now) trk_first = trk_now;
          end else if (trk_dsg_tmr >= cfg_hold) begin
            // restart: discharge resumed after a hold, start from held charge
            if (int'(t.soc) + int'(cfg_drop) <= int'(trk_held) || t.soc < cfg_low) begin
              trk_dsg_tmr = '0;
              trk_pending = 1'b1;
              trk_first   = DOD_W'(depth_from(trk_held));
              trk_now     = DOD_W'(d);
            end
          end else begin
            trk_dsg_tmr = trk_dsg_tmr + 1'b1;
          end
          trk_chg_tmr = 1'b0;
        end else begin
          if (d > int'(trk_now)) begin
            trk_pending = 1'b1;
            trk_now     = DOD_W'(d);
          end
          if (t.direction == DIR_CHG && trk_pending && trk_saved_ok) begin
            if (trk_chg_tmr) begin
              // push newest first, drop oldest when full
              len = (hist_fill < HIST_DEPTH - 1) ? hist_fill : HIST_DEPTH - 1;
              mx  = trk_now;
              sum = trk_now;
              num = 1;
              for (i = len; i > 0; i--) begin
                v = hist_mem[i-1];
                if (v > mx) mx = v;
                sum += v;
                num++;
                hist_mem[i] = DOD_W'(v);
              end
              hist_mem[0] = trk_now;
              trk_max = DOD_W'(mx);
              trk_avg = DOD_W'(sum / num);
              hist_fill = (hist_fill < HIST_DEPTH) ? hist_fill + 1 : HIST_DEPTH;
              trk_chg_tmr = 1'b0;
              trk_pending = 1'b0;
              created = 1'b1;
            end else begin
              trk_chg_tmr = 1'b1;
            end
          end else begin
            trk_chg_tmr = 1'b0;
          end
          if (t.direction == DIR_CHG) begin
            trk_dsg_tmr = '0;
            trk_held    = t.soc;
          end
        end

        if (!trk_saved_ok) begin
          trk_pending  = 1'b1;
          trk_saved    = trk_now;
          trk_saved_ok = 1'b1;
        end else if (created) begin
          store = STORE_ALL;
          trk_saved = trk_now;
        end else begin
          diff = (trk_now >= trk_saved) ? int'(trk_now) - int'(trk_saved)
                                        : int'(trk_saved) - int'(trk_now);
          if (diff >= int'(cfg_save) || (diff >= 1 && t.direction != DIR_DSG)) begin
            store = STORE_NOW;
            trk_saved = trk_now;
          end
        end
      end

      r.now_dod        = trk_now;
      r.first_dod      = trk_first;
      r.max_dod        = trk_max;
      r.avg_dod        = trk_avg;
      r.history_count  = CNT_OUT_W'((hist_fill > CNT_SAT) ? CNT_SAT : hist_fill);
      r.record_created = created;
      r.store_action   = store;
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    begin
      mism_count++;
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  dod_res_t seen_res, want_res, pred_res;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        track_tick({in_ch.opcode, in_ch.init_phase, in_ch.direction, in_ch.soc}, pred_res);
        stats_due.push_back(drill_typed ? drill_want : pred_res);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        seen_res = {out_ch.now_dod, out_ch.first_dod, out_ch.max_dod, out_ch.avg_dod,
                    out_ch.history_count, out_ch.record_created, out_ch.store_action};
        if (stats_due.size() == 0) begin
          flag_mismatch("result with nothing expected", 0, 0);
        end else begin
          want_res = stats_due.pop_front();
          if (seen_res.now_dod !== want_res.now_dod)
            flag_mismatch("now_dod", seen_res.now_dod, want_res.now_dod);
          if (seen_res.first_dod !== want_res.first_dod)
            flag_mismatch("first_dod", seen_res.first_dod, want_res.first_dod);
          if (seen_res.max_dod !== want_res.max_dod)
            flag_mismatch("max_dod", seen_res.max_dod, want_res.max_dod);
          if (seen_res.avg_dod !== want_res.avg_dod)
            flag_mismatch("avg_dod", seen_res.avg_dod, want_res.avg_dod);
          if (seen_res.history_count !== want_res.history_count)
            flag_mismatch("history_count", seen_res.history_count, want_res.history_count);
          if (seen_res.record_created !== want_res.record_created)
            flag_mismatch("record_created", seen_res.record_created, want_res.record_created);
          if (seen_res.store_action !== want_res.store_action)
            flag_mismatch("store_action", seen_res.store_action, want_res.store_action);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic push_tick(input tick_t t, input bit typed, input dod_res_t want);
    int gap;
    begin
      gap = steady ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      @(negedge clk);
      drill_typed = typed;
      drill_want  = want;
      in_ch.valid      <= 1'b1;
      in_ch.opcode     <= t.opcode;
      in_ch.init_phase <= t.init_phase;
      in_ch.direction  <= t.direction;
      in_ch.soc        <= t.soc;
      do @(posedge clk); while (!in_ch.ready);
    end
  endtask

  // Hold off until every result is back, then let the block go quiet
  task automatic settle;
    begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= data;
      case (idx)
        CFG_INIT_NOW:   trk_now   = data[DOD_W-1:0];
        CFG_INIT_FIRST: trk_first = data[DOD_W-1:0];
        CFG_INIT_MAX:   trk_max   = data[DOD_W-1:0];
        CFG_INIT_AVG:   trk_avg   = data[DOD_W-1:0];
        CFG_HOLD:       cfg_hold  = data[TMR_W-1:0];
        CFG_DROP:       cfg_drop  = data[DOD_W-1:0];
        CFG_LOW:        cfg_low   = data[DOD_W-1:0];
        default:        cfg_save  = data[DOD_W-1:0];
      endcase
    end
  endtask

  task automatic apply_plan;
    begin
      for (int k = int'(CFG_INIT_NOW); k <= int'(CFG_SAVE); k++)
        write_reg(CFG_IDX_W'(k), reg_plan[k]);
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic run_phase(input int budget, input bit with_clear);
    int sent, kind, len, k;
    tick_t t;
    bit noise;
    begin
      sent = 0;
      while (sent < budget) begin
        kind   = $urandom_range(0, 99);
        steady = ($urandom_range(0, 7) == 0);
        if (kind < 40)      len = $urandom_range(1, 12);
        else if (kind < 68) len = $urandom_range(1, 5);
        else if (kind < 76) len = $urandom_range(1, 4);
        else if (kind < 82) len = $urandom_range(1, 3);
        else                len = 1;
        for (k = 0; k < len; k++) begin
          noise = 1'b0;
          t.opcode     = OP_TICK;
          t.init_phase = 1'b0;
          t.direction  = DIR_IDLE;
          if (kind < 40) begin
            soc_walk -= $urandom_range(0, 40);
            if (soc_walk < 0) soc_walk = 0;
            t.direction = DIR_DSG;
          end else if (kind < 68) begin
            soc_walk += $urandom_range(0, 80);
            if (soc_walk > FULL_SOC) soc_walk = FULL_SOC;
            t.direction = DIR_CHG;
          end else if (kind < 76) begin
            t.direction = $urandom_range(0, 1) ? DIR_RSVD : DIR_IDLE;
          end else if (kind < 82) begin
            t.init_phase = 1'b1;
            t.direction  = DIR_W'($urandom_range(0, 3));
          end else if (kind < 84 && with_clear) begin
            t.opcode = OP_CLEAR;
          end else begin
            noise = 1'b1;
            t.opcode     = (with_clear && $urandom_range(0, 31) == 0) ? OP_CLEAR : OP_TICK;
            t.init_phase = 1'($urandom_range(0, 1));
            t.direction  = DIR_W'($urandom_range(0, 3));
            t.soc        = SOC_W'($urandom_range(0, 1023));
          end
          if (!noise) begin
            t.soc = SOC_W'(soc_walk);
            // out-of-range charge now and then while charging
            if (t.direction == DIR_CHG && $urandom_range(0, 15) == 0)
              t.soc = SOC_W'($urandom_range(FULL_SOC + 1, 1023));
          end
          push_tick(t, 1'b0, ALL_ZERO);
          sent++;
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    int budget [NUM_PHASES];
    budget = '{350, 350, 150, 300, 270, 270};
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_TICK;
    in_ch.init_phase = 1'b0;
    in_ch.direction  = DIR_IDLE;
    in_ch.soc        = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_INIT_NOW;
    cfg_data = '0;
    rst_n    = 1'b0;

    drill = '{
      '{'{OP_TICK,  1'b1, DIR_CHG,  10'd1000}, 1'b1, ALL_ZERO},
      '{'{OP_CLEAR, 1'b1, DIR_DSG,  10'd0},    1'b1,
        '{10'd0, 10'd0, 10'd0, 10'd0, 6'd0, 1'b0, STORE_ALL}},
      '{'{OP_TICK,  1'b0, DIR_IDLE, 10'd1023}, 1'b1, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_RSVD, 10'd1000}, 1'b1, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd0},    1'b1,
        '{10'd1000, 10'd0, 10'd0, 10'd0, 6'd0, 1'b0, STORE_NOW}},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd0},    1'b1,
        '{10'd1000, 10'd0, 10'd0, 10'd0, 6'd0, 1'b0, STORE_NONE}},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd0},    1'b1,
        '{10'd1000, 10'd0, 10'd1000, 10'd1000, 6'd1, 1'b1, STORE_ALL}},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd1000}, 1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd512},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd511},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_IDLE, 10'd0},    1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b1, DIR_DSG,  10'd1023}, 1'b0, ALL_ZERO},
      '{'{OP_CLEAR, 1'b0, DIR_IDLE, 10'd0},    1'b1,
        '{10'd0, 10'd0, 10'd0, 10'd0, 6'd0, 1'b0, STORE_ALL}},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd700},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd800},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd800},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd341},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_DSG,  10'd682},  1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd1001}, 1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_CHG,  10'd1000}, 1'b0, ALL_ZERO},
      '{'{OP_TICK,  1'b0, DIR_IDLE, 10'd0},    1'b0, ALL_ZERO}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (drill[i]) push_tick(drill[i].t, drill[i].typed, drill[i].want);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          // initial stats and low limit at the top of their range, restart on nearly any drop
          reg_plan[CFG_INIT_NOW]   = 12'd1000;
          reg_plan[CFG_INIT_FIRST] = 12'd1000;
          reg_plan[CFG_INIT_MAX]   = 12'd1000;
          reg_plan[CFG_INIT_AVG]   = 12'd1000;
          reg_plan[CFG_HOLD]       = 12'd0;
          reg_plan[CFG_DROP]       = 12'd0;
          reg_plan[CFG_LOW]        = 12'd1000;
          reg_plan[CFG_SAVE]       = 12'd0;
        end
        1: begin
          reg_plan[CFG_INIT_NOW]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_FIRST] = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_MAX]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_AVG]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_HOLD]       = 12'd1;
          reg_plan[CFG_DROP]       = 12'd20;
          reg_plan[CFG_LOW]        = 12'd100;
          reg_plan[CFG_SAVE]       = 12'd10;
        end
        2: begin
          reg_plan[CFG_INIT_NOW]   = 12'd0;
          reg_plan[CFG_INIT_FIRST] = 12'd0;
          reg_plan[CFG_INIT_MAX]   = 12'd0;
          reg_plan[CFG_INIT_AVG]   = 12'd0;
          reg_plan[CFG_HOLD]       = 12'd4095;
          reg_plan[CFG_DROP]       = 12'd1000;
          reg_plan[CFG_LOW]        = 12'd0;
          reg_plan[CFG_SAVE]       = 12'd1000;
        end
        default: begin
          reg_plan[CFG_INIT_NOW]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_FIRST] = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_MAX]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_INIT_AVG]   = CFG_DATA_W'($urandom_range(0, 1000));
          reg_plan[CFG_HOLD]       = CFG_DATA_W'($urandom_range(0, 8));
          reg_plan[CFG_DROP]       = CFG_DATA_W'($urandom_range(0, 80));
          reg_plan[CFG_LOW]        = CFG_DATA_W'($urandom_range(0, 200));
          reg_plan[CFG_SAVE]       = CFG_DATA_W'($urandom_range(0, 100));
        end
      endcase
      apply_plan();
      // keep the history across the first two phases so it overflows
      run_phase(budget[ph], ph >= 2);
      settle();
    end

    repeat (20) @(posedge clk);
    if (mism_count == 0 && stats_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dod_pkg.sv
hdl/dod_in_if.sv
hdl/dod_out_if.sv
hdl/dod_hist_cell.sv
hdl/dod_divider.sv
hdl/dod_history.sv
hdl/battery_dod_history_tracker.sv
tb/tb_battery_dod_history_tracker.sv
